// ----- sv/earliest_free_server_assigner_assert.svh -----
// Assertion macros for the earliest-free server assigner.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef EARLIEST_FREE_SERVER_ASSIGNER_ASSERT_SVH
`define EARLIEST_FREE_SERVER_ASSIGNER_ASSERT_SVH
`ifndef SYNTHESIS
`define EFSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define EFSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EFSA_ASSERT_IMP(lbl, ante, cons, msg)
`define EFSA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/efsa_pkg.sv -----
`timescale 1ns / 1ps

package efsa_pkg;

  localparam int MaxServers = 16;
  localparam int IdxW       = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int CntW       = $clog2(MaxServers + 1);
  localparam int TimeW      = 32;
  localparam int SrvW       = 5;
  localparam int CfgW       = 5;

  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef logic [TimeW-1:0] time_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [SrvW-1:0]  srv_t;

  // Winner of the earliest-free search.
  typedef struct packed {
    idx_t  idx;
    time_t t;
  } min_t;

  // 1-based server number, masked to the output width.
  function automatic srv_t srv_num(idx_t i);
    return SrvW'({1'b0, i} + (IdxW + 1)'(1));
  endfunction

endpackage

// ----- sv/earliest_free_server_assigner.sv -----
// Earliest-free server assigner.
// Each job passes stage 1, stage 2 and the output register to the master side.
// Throughput: one job per cycle unless the output stalls; the earliest-free
//   search and one 32-bit add sit between the input and free-time registers.
// Reset (rst_ni low, asynchronous): all free times clear to zero, the
//   server count returns to 1 and every pipeline stage empties.
`timescale 1ns / 1ps

module earliest_free_server_assigner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: number of servers in use
  input  logic                      cfg_we_i,
  input  logic [efsa_pkg::CfgW-1:0] cfg_wdata_i,
  // job input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,  // [31:0] service_time
  input  logic                      s_axis_tuser,  // [0] new_case
  // assignment output
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // [4:0] assigned_server, [9:5] next_server
  output logic                      m_axis_tuser   // [0] saturated
);

  localparam int OutTdataW = ((2 * efsa_pkg::SrvW + 7) / 8) * 8;

  // ---------------------------------------------------------------------------
  // Configuration: server count, clamped to 1..MaxServers when used.
  // ---------------------------------------------------------------------------
  logic [efsa_pkg::CfgW-1:0] cfg_q;
  logic [efsa_pkg::CntW-1:0] active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= efsa_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (cfg_q == '0) begin
      active = efsa_pkg::CntW'(1);
    end else if (int'(cfg_q) > efsa_pkg::MaxServers) begin
      active = efsa_pkg::CntW'(efsa_pkg::MaxServers);
    end else begin
      active = efsa_pkg::CntW'(cfg_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control.
  // Stage 1 holds the accepted job. When it advances it reads the search
  // result, picks the server and writes the new free time.
  // Stage 2 holds the pick. When it advances, the free times already carry
  // its update and nothing newer, so the same search result is its
  // next_server. Stage 1 only advances into a stage 2 that is empty or moves
  // out in the same cycle, which keeps that ordering under any output stall.
  // The output register parts the master side from the rest.
  // ---------------------------------------------------------------------------
  logic                    s1_valid_q;
  logic                    s1_new_case_q;
  efsa_pkg::time_t         s1_svc_q;
  logic                    s2_valid_q;
  efsa_pkg::srv_t          s2_srv_q;
  logic                    s2_sat_q;
  logic                    out_valid_q;
  logic [OutTdataW-1:0]    out_tdata_q;
  logic                    out_sat_q;

  logic                    s1_advance;
  logic                    s2_advance;

  assign s2_advance    = s2_valid_q && (!out_valid_q || m_axis_tready);
  assign s1_advance    = s1_valid_q && (!s2_valid_q || s2_advance);
  assign s_axis_tready = !s1_valid_q || s1_advance;

  // ---------------------------------------------------------------------------
  // Free times and the earliest-free search.
  // ---------------------------------------------------------------------------
  efsa_pkg::time_t free_q [efsa_pkg::MaxServers];
  efsa_pkg::min_t  root;

  efsa_min_tree u_min_tree (
    .free_i   (free_q),
    .active_i (active),
    .root_o   (root)
  );

  // A new case clears everything first, so server 1 at time zero wins.
  efsa_pkg::idx_t          s1_pick;
  efsa_pkg::time_t         s1_base;
  logic [efsa_pkg::TimeW:0] s1_sum;
  logic                    s1_sat;
  efsa_pkg::time_t         s1_new_t;

  assign s1_pick  = s1_new_case_q ? '0 : root.idx;
  assign s1_base  = s1_new_case_q ? '0 : root.t;
  assign s1_sum   = {1'b0, s1_base} + {1'b0, s1_svc_q};
  assign s1_sat   = s1_sum[efsa_pkg::TimeW];
  // Clip at the top of the range on carry out.
  assign s1_new_t = s1_sat ? efsa_pkg::TimeMax : s1_sum[efsa_pkg::TimeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < efsa_pkg::MaxServers; i++) begin
        free_q[i] <= '0;
      end
    end else if (s1_advance) begin
      for (int i = 0; i < efsa_pkg::MaxServers; i++) begin
        if (efsa_pkg::IdxW'(i) == s1_pick) begin
          free_q[i] <= s1_new_t;
        end else if (s1_new_case_q) begin
          free_q[i] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_advance || s2_advance) begin
        s2_valid_q <= s1_advance;
      end
      if (!out_valid_q || m_axis_tready) begin
        out_valid_q <= s2_advance;
      end
    end
  end

  // Payload: load on transfer or advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_new_case_q <= s_axis_tuser;
      s1_svc_q      <= s_axis_tdata;
    end
    if (s1_advance) begin
      s2_srv_q <= efsa_pkg::srv_num(s1_pick);
      s2_sat_q <= s1_sat;
    end
    if (s2_advance) begin
      out_tdata_q <= OutTdataW'({efsa_pkg::srv_num(root.idx), s2_srv_q});
      out_sat_q   <= s2_sat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_sat_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "earliest_free_server_assigner_assert.svh"

  `EFSA_ASSERT_IMP(a_assigned_in_range, out_valid_q, (out_tdata_q[efsa_pkg::SrvW-1:0] != '0) && (int'(out_tdata_q[efsa_pkg::SrvW-1:0]) <= int'(active)), "assigned server outside active range")
  `EFSA_ASSERT_NXT(a_sat_clips, s1_advance && s1_sat, free_q[$past(s1_pick)] == efsa_pkg::TimeMax, "saturated pick did not clip free time")
  `EFSA_ASSERT_NXT(a_s2_holds, s2_valid_q && !s2_advance, s2_valid_q && $stable(s2_srv_q), "stalled pick lost")

endmodule

// ----- sv/efsa_min_tree.sv -----
`timescale 1ns / 1ps

module efsa_min_tree (
  input  efsa_pkg::time_t            free_i [efsa_pkg::MaxServers],
  input  logic [efsa_pkg::CntW-1:0]  active_i,
  output efsa_pkg::min_t             root_o
);

  localparam int Levels = $clog2(efsa_pkg::MaxServers);
  localparam int Leaves = 1 << Levels;

  logic                  node_vld [1:2*Leaves-1];
  efsa_pkg::idx_t        node_idx [1:2*Leaves-1];
  efsa_pkg::time_t       node_t   [1:2*Leaves-1];
  logic                  take_r;

  // Binary tree: the left child always covers lower numbers, so it wins ties.
  always_comb begin
    take_r = 1'b0;
    for (int i = 0; i < Leaves; i++) begin
      node_vld[Leaves+i] = 1'b0;
      node_t[Leaves+i]   = '0;
      node_idx[Leaves+i] = efsa_pkg::IdxW'(i);
      if (i < efsa_pkg::MaxServers) begin
        node_vld[Leaves+i] = (i < int'(active_i));
        node_t[Leaves+i]   = free_i[i];
      end
    end
    for (int k = Leaves - 1; k >= 1; k--) begin
      take_r = node_vld[2*k+1] && (!node_vld[2*k] || (node_t[2*k+1] < node_t[2*k]));
      if (take_r) begin
        node_vld[k] = node_vld[2*k+1];
        node_idx[k] = node_idx[2*k+1];
        node_t[k]   = node_t[2*k+1];
      end else begin
        node_vld[k] = node_vld[2*k];
        node_idx[k] = node_idx[2*k];
        node_t[k]   = node_t[2*k];
      end
    end
    root_o.idx = node_idx[1];
    root_o.t   = node_t[1];
  end

endmodule

// ----- dv/server_assignment_checker.sv -----
`timescale 1ns / 1ps

module server_assignment_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [efsa_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,  // [31:0] service_time
  input  logic                      s_axis_tuser,  // [0] new_case
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [15:0]               m_axis_tdata,  // [4:0] assigned_server, [9:5] next_server
  input  logic                      m_axis_tuser,  // [0] saturated
  output int unsigned               pending_o,
  output int unsigned               errors_o
);

  typedef struct packed {
    efsa_pkg::srv_t server;
    efsa_pkg::srv_t next_free;
    logic           saturated;
  } assignment_t;

  efsa_pkg::time_t           free_at [efsa_pkg::MaxServers];
  logic [efsa_pkg::CfgW-1:0] server_count;
  assignment_t               expected_q [$];
  int unsigned               mismatches = 0;

  // Clamp the register to 1..MaxServers.
  function automatic int unsigned live_servers();
    if (server_count == '0) begin
      return 1;
    end
    if (int'(server_count) > efsa_pkg::MaxServers) begin
      return efsa_pkg::MaxServers;
    end
    return int'(server_count);
  endfunction

  function automatic int unsigned earliest_free(input int unsigned n);
    int unsigned best = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (free_at[i] < free_at[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t server_assignment_checker: %s", $time, msg);
    mismatches++;
  endtask

  // Assign one job and queue the assignment it must produce.
  task automatic take_job(input logic fresh, input efsa_pkg::time_t svc);
    int unsigned n;
    int unsigned pick;
    logic [efsa_pkg::TimeW:0] sum;
    assignment_t want;
    if (fresh) begin
      foreach (free_at[i]) free_at[i] = '0;
    end
    n    = live_servers();
    pick = earliest_free(n);
    sum  = {1'b0, free_at[pick]} + {1'b0, svc};
    want.saturated = sum[efsa_pkg::TimeW];
    free_at[pick]  = sum[efsa_pkg::TimeW] ? efsa_pkg::TimeMax : sum[efsa_pkg::TimeW-1:0];
    want.server    = efsa_pkg::SrvW'(pick + 1);
    want.next_free = efsa_pkg::SrvW'(earliest_free(n) + 1);
    expected_q.push_back(want);
  endtask

  task automatic check_assignment(input logic [15:0] data, input logic sat);
    assignment_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("assignment %h/%b with no job outstanding", data, sat));
      return;
    end
    want = expected_q.pop_front();
    if (data[4:0] !== want.server) begin
      report_mismatch($sformatf("assigned_server %0d, want %0d", data[4:0], want.server));
    end
    if (data[9:5] !== want.next_free) begin
      report_mismatch($sformatf("next_server %0d, want %0d", data[9:5], want.next_free));
    end
    if (sat !== want.saturated) begin
      report_mismatch($sformatf("saturated %b, want %b", sat, want.saturated));
    end
  endtask

  // Results leave the block only after its registered stages, so compare the
  // outgoing transfer before queueing the incoming one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (free_at[i]) free_at[i] = '0;
      server_count = efsa_pkg::CfgW'(1);
      expected_q.delete();
      pending_o <= 0;
      errors_o  <= mismatches;
    end else begin
      if (cfg_we_i) begin
        server_count = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_assignment(m_axis_tdata, m_axis_tuser);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_job(s_axis_tuser, s_axis_tdata);
      end
      pending_o <= expected_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// ----- dv/earliest_free_server_assigner_tb.sv -----
`timescale 1ns / 1ps

module earliest_free_server_assigner_tb;

  localparam int JobsPerBlock = 95;
  localparam int Blocks       = 10;
  // Cycles without any transfer before the run is declared hung.
  localparam int StallLimit   = 2000;
  // Pipeline depth plus margin; wait this long once the result queue drains.
  localparam int SettleCycles = 4;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [efsa_pkg::CfgW-1:0] cfg_wdata_i   = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [31:0]               s_axis_tdata  = '0;  // [31:0] service_time
  logic                      s_axis_tuser  = 1'b0;  // [0] new_case
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [15:0]               m_axis_tdata;  // [4:0] assigned_server, [9:5] next_server
  logic                      m_axis_tuser;  // [0] saturated

  int unsigned tx_idle_pct  = 19;
  int unsigned rx_idle_pct  = 69;
  int unsigned pending;
  int unsigned errors;
  int unsigned stall_cycles = 0;

  earliest_free_server_assigner i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  server_assignment_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: drop tready at random in rx_idle_pct percent of the cycles.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("earliest_free_server_assigner_tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offer one job, idling first at the sender's rate; return right after the
  // transfer edge so the next call drives tvalid only once in that step.
  task automatic send_job(input logic fresh, input efsa_pkg::time_t svc);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= svc;
    s_axis_tuser  <= fresh;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold the sender until every queued assignment has come back, then let
  // the pipeline settle. The first wait skips the stale count of the edge
  // that took the last job.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_servers(input logic [efsa_pkg::CfgW-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly tiny times so ties are common, plus wide and near-max values
  // that push servers into saturation.
  function automatic efsa_pkg::time_t random_service();
    case ($urandom_range(9))
      0, 1, 2, 3: return efsa_pkg::time_t'($urandom_range(3));
      4, 5, 6:    return efsa_pkg::time_t'($urandom_range(1000));
      7:          return efsa_pkg::time_t'($urandom());
      8:          return efsa_pkg::TimeMax - efsa_pkg::time_t'($urandom_range(3));
      default:    return 32'h8000_0000 + efsa_pkg::time_t'($urandom_range(255));
    endcase
  endfunction

  // Server counts per block: zero, above the maximum and all-ones included;
  // no new case between blocks, so shrinking and regrowing the count keeps
  // the idle entries' old times in play.
  function automatic logic [efsa_pkg::CfgW-1:0] servers_for_block(input int b);
    case (b)
      0:       return efsa_pkg::CfgW'(16);
      1:       return efsa_pkg::CfgW'(0);
      2:       return efsa_pkg::CfgW'(7);
      3:       return efsa_pkg::CfgW'(31);
      4:       return efsa_pkg::CfgW'(1);
      5:       return efsa_pkg::CfgW'(17);
      6:       return efsa_pkg::CfgW'(2);
      7:       return efsa_pkg::CfgW'(12);
      8:       return efsa_pkg::CfgW'(16);
      default: return efsa_pkg::CfgW'($urandom_range(31));
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single server after reset: fill to the maximum exactly, then clip.
    send_job(1'b1, '0);
    send_job(1'b0, efsa_pkg::TimeMax);
    send_job(1'b0, 32'd1);
    send_job(1'b0, '0);
    drain();

    // Three servers: all saturated ties go to server 1; then plain ties.
    write_servers(efsa_pkg::CfgW'(3));
    send_job(1'b1, efsa_pkg::TimeMax);
    send_job(1'b0, efsa_pkg::TimeMax);
    send_job(1'b0, efsa_pkg::TimeMax);
    send_job(1'b0, 32'd1);
    send_job(1'b0, '0);
    send_job(1'b1, 32'd7);
    send_job(1'b0, 32'd7);
    send_job(1'b0, 32'd7);
    send_job(1'b0, 32'd7);
    drain();

    // Full set of servers, alternating bit patterns.
    write_servers(efsa_pkg::CfgW'(16));
    send_job(1'b1, 32'd5);
    send_job(1'b0, 32'hAAAA_5555);
    send_job(1'b0, 32'h5555_AAAA);
    send_job(1'b0, '0);

    // Random blocks; each starts once the pipeline is idle and writes its own count.
    for (int b = 0; b < Blocks; b++) begin
      drain();
      write_servers(servers_for_block(b));
      if (b < 4) begin
        tx_idle_pct = 19;
        rx_idle_pct = 69;
      end else if (b < 7) begin
        tx_idle_pct = 69;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int j = 0; j < JobsPerBlock; j++) begin
        send_job($urandom_range(24) == 0, random_service());
      end
    end

    drain();
    if (errors == 0) begin
      $display("earliest_free_server_assigner_tb: done, clean");
    end else begin
      $display("earliest_free_server_assigner_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- earliest_free_server_assigner.f -----
+incdir+sv
sv/efsa_pkg.sv
sv/efsa_min_tree.sv
sv/earliest_free_server_assigner.sv
dv/server_assignment_checker.sv
dv/earliest_free_server_assigner_tb.sv
